FILE: src/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache.
// Used by lkvc_ctrl, lkvc_dpath and lru_key_value_cache_top; depends on nothing.
`default_nettype none

package lkvc_pkg;

  localparam int unsigned CAP_W       = 5;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned IN_KEY_W    = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // Step commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic look;
    logic upd;
  } lkvc_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic is_put;
    logic out_busy;
  } lkvc_sts_t;

endpackage

`default_nettype wire

FILE: src/lru_key_value_cache_top.sv
// Top level of the LRU key-value cache: stream ports, controller and datapath.
// Depends on lkvc_pkg, lkvc_ctrl and lkvc_dpath.
//
// Requests arrive on the s_axis channel: tuser is the command (0 get, 1 put),
// tdata holds the key in bits 31:0 and the value in bits 63:32. Each get gives
// one result on the m_axis channel, tuser the hit flag and tdata the stored
// value, zero on a miss. Puts give no result. The capacity register is written
// on the cfg channel, which is always ready; the user must see that it is
// changed only while idle, and the block itself does not enforce this. An item
// passes through the transfer, the parallel key compare across all entries with
// the value memory read, and the recency and entry update. A result is valid in
// the cycle after the update. A new item is taken only once the last one has
// finished its update. The output register holds a result while the receiver
// stalls; a following put proceeds, and a following get waits in its update step.
// Reset empties the store, clears all recency ranks and sets capacity to 16;
// the block accepts items as soon as reset is released.
`default_nettype none

module lru_key_value_cache_top
  import lkvc_pkg::*;
#(
  parameter int unsigned DEPTH    = 16,
  parameter int unsigned KEY_BITS = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [IN_KEY_W+DATA_W-1:0]  s_axis_tdata,  // key, value
  input  wire logic                        s_axis_tuser,  // cmd
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [DATA_W-1:0]                m_axis_tdata,  // read_value
  output logic                             m_axis_tuser,  // hit
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [CAP_W-1:0]            cfg_data_i     // capacity
);

  lkvc_cmd_t cmd;
  lkvc_sts_t sts;

  assign cfg_ready_o = 1'b1;

  lkvc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lkvc_dpath #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_cmd_i    (s_axis_tuser),
    .in_key_i    (s_axis_tdata[IN_KEY_W-1:0]),
    .in_value_i  (s_axis_tdata[IN_KEY_W+DATA_W-1:IN_KEY_W]),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_hit_o   (m_axis_tuser),
    .out_value_o (m_axis_tdata)
  );

endmodule

`default_nettype wire

FILE: src/lkvc_ctrl.sv
// Controller state machine for the LRU key-value cache: accept, lookup, update.
// Depends on lkvc_pkg for the command and status structs.
`default_nettype none

module lkvc_ctrl
  import lkvc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire lkvc_sts_t sts_i,
  output lkvc_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOOK = 3'b010,
    ST_UPD  = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    cmd_o.load = in_ready_o && in_valid_i;
    cmd_o.look = (state_q == ST_LOOK);
    cmd_o.upd  = (state_q == ST_UPD) && (sts_i.is_put || !sts_i.out_busy);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LOOK;
      end
      ST_LOOK: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (cmd_o.upd) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/lkvc_dpath.sv
// Datapath of the LRU key-value cache: key array with parallel compare, recency ranks,
// value memory, capacity register and output register. Depends on lkvc_pkg.
`default_nettype none

module lkvc_dpath
  import lkvc_pkg::*;
#(
  parameter int unsigned DEPTH    = 16,
  parameter int unsigned KEY_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire lkvc_cmd_t             cmd_i,
  output lkvc_sts_t                  sts_o,
  input  wire logic                  in_cmd_i,
  input  wire logic [IN_KEY_W-1:0]   in_key_i,
  input  wire logic [DATA_W-1:0]     in_value_i,
  input  wire logic                  cfg_valid_i,
  input  wire logic [CAP_W-1:0]      cfg_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       out_hit_o,
  output logic [DATA_W-1:0]          out_value_o
);

  localparam int unsigned RW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (OW > CAP_W) ? OW : CAP_W;

  logic                cmd_q;
  logic [KEY_BITS-1:0] key_q;
  logic [DATA_W-1:0]   val_q;

  logic [KEY_BITS-1:0] key_mem [DEPTH];
  logic [DATA_W-1:0]   val_mem [DEPTH];
  logic [RW-1:0]       rank_q  [DEPTH];
  logic [DEPTH-1:0]    valid_q;
  logic [OW-1:0]       occ_q;
  logic [CAP_W-1:0]    cap_q;

  logic [DEPTH-1:0] match, victim, free_oh, tgt_oh;
  logic             hit, need_evict;
  logic [RW-1:0]    hit_idx, hit_rank, tgt_idx, occ_m1;
  logic [CW-1:0]    cap_ext, eff_cap;
  logic signed [IN_KEY_W-1:0] key_in;

  logic             hit_q, evict_q;
  logic [RW-1:0]    hit_rank_q, tgt_idx_q;
  logic [DEPTH-1:0] tgt_oh_q;
  logic [DATA_W-1:0] rdata_q;

  logic             out_valid_q, out_hit_q;
  logic [DATA_W-1:0] out_value_q;

  assign key_in = in_key_i;

  always_comb begin
    cap_ext = CW'(cap_q);
    if (cap_q == '0) begin
      eff_cap = CW'(1);
    end else if (cap_ext > CW'(DEPTH)) begin
      eff_cap = CW'(DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
    need_evict = CW'(occ_q) >= eff_cap;
    occ_m1     = RW'(occ_q - OW'(1));
    free_oh    = ~valid_q & (valid_q + DEPTH'(1));
    hit_idx    = '0;
    hit_rank   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      match[i]  = valid_q[i] && (key_mem[i] == key_q);
      victim[i] = valid_q[i] && (rank_q[i] == occ_m1);
      if (match[i]) begin
        hit_idx  = hit_idx | RW'(i);
        hit_rank = hit_rank | rank_q[i];
      end
    end
    hit = |match;
    if (hit) begin
      tgt_oh = match;
    end else if (need_evict) begin
      tgt_oh = victim;
    end else begin
      tgt_oh = free_oh;
    end
    tgt_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (tgt_oh[i]) tgt_idx = tgt_idx | RW'(i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= in_cmd_i;
      key_q <= KEY_BITS'(key_in);
      val_q <= in_value_i;
    end
    if (cmd_i.look) begin
      hit_q      <= hit;
      evict_q    <= need_evict;
      hit_rank_q <= hit_rank;
      tgt_idx_q  <= tgt_idx;
      tgt_oh_q   <= tgt_oh;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.look) begin
      rdata_q <= val_mem[hit_idx];
    end
    if (cmd_i.upd && (cmd_q == CMD_PUT)) begin
      val_mem[tgt_idx_q] <= val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (cmd_i.upd && (cmd_q == CMD_PUT) && !hit_q && tgt_oh_q[i]) begin
        key_mem[i] <= key_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        rank_q[i] <= '0;
      end
    end else if (cmd_i.upd) begin
      if (hit_q) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (tgt_oh_q[i]) begin
            rank_q[i] <= '0;
          end else if (valid_q[i] && (rank_q[i] < hit_rank_q)) begin
            rank_q[i] <= rank_q[i] + RW'(1);
          end
        end
      end else if (cmd_q == CMD_PUT) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (tgt_oh_q[i]) begin
            valid_q[i] <= 1'b1;
            rank_q[i]  <= '0;
          end else if (valid_q[i]) begin
            rank_q[i] <= rank_q[i] + RW'(1);
          end
        end
        if (!evict_q) occ_q <= occ_q + OW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.upd && (cmd_q == CMD_GET)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd && (cmd_q == CMD_GET)) begin
      out_hit_q   <= hit_q;
      out_value_q <= hit_q ? rdata_q : '0;
    end
  end

  assign sts_o.is_put   = (cmd_q == CMD_PUT);
  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_hit_o      = out_hit_q;
  assign out_value_o    = out_value_q;

  a_occ_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    OW'($countones(valid_q)) == occ_q)
    else $error("occupancy differs from the number of valid entries");

  a_key_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.look |-> $onehot0(match))
    else $error("key present in more than one entry");

  a_victim_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.look && !hit && need_evict) |-> $onehot(victim))
    else $error("no single least recent entry to evict");

  a_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.look && !hit && !need_evict) |-> $onehot(free_oh))
    else $error("insert without a free slot");

  a_get_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.upd && (cmd_q == CMD_GET)) |=> out_valid_q)
    else $error("lookup finished without a result");

endmodule

`default_nettype wire

FILE: bench/lru_key_value_cache_top_tb.sv
// Self-checking testbench for lru_key_value_cache_top: get and put streams with
// random idling and back pressure, checked against an in-bench LRU predictor.
// Depends on lkvc_pkg and the lru_key_value_cache_top RTL.

module lru_key_value_cache_top_tb;
  import lkvc_pkg::*;

  localparam int CACHE_DEPTH = 16;
  localparam int SETTLE = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 80;
  localparam int NUM_ROWS = 25;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] value;
  } read_t;

  typedef enum logic {ROW_REQ, ROW_CAP} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    logic              cmd;
    logic [31:0]       key;
    logic [31:0]       val;
    bit                typed;
    logic              t_hit;
    logic [31:0]       t_val;
  } dir_row_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [IN_KEY_W+DATA_W-1:0] s_axis_tdata = '0;  // key, value
  logic                       s_axis_tuser = CMD_GET;  // cmd
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [DATA_W-1:0]          m_axis_tdata;  // read_value
  logic                       m_axis_tuser;  // hit
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [CAP_W-1:0]           cfg_data_i = '0;  // capacity

  logic [31:0]      c_key [CACHE_DEPTH];
  logic [31:0]      c_val [CACHE_DEPTH];
  bit               c_vld [CACHE_DEPTH];
  int unsigned      c_rank [CACHE_DEPTH];
  int unsigned      c_occ;
  logic [CAP_W-1:0] c_cap;

  read_t reads_due [$];
  int    errors = 0;
  int    cycles = 0;
  bit    quiet = 1'b0;
  int    stall_req = 0;
  int    stall_seen = 0;
  int    stall_left = 0;

  dir_row_t dir_rows [NUM_ROWS] = '{
    '{ROW_REQ, CMD_GET, 32'h0000_0000, 32'h0000_0000, 1, 1'b0, 32'h0000_0000},
    '{ROW_REQ, CMD_PUT, 32'h8000_0000, 32'h7fff_ffff, 0, 1'b0, 32'h0000_0000},
    '{ROW_REQ, CMD_GET, 32'h8000_0000, 32'h0000_0000, 1, 1'b1, 32'h7fff_ffff},
    '{ROW_REQ, CMD_PUT, 32'h7fff_ffff, 32'h8000_0000, 0, 1'b0, 32'h0000_0000},
    '{ROW_REQ, CMD_GET, 32'h7fff_ffff, 32'h0000_0000, 1, 1'b1, 32'h8000_0000},
    '{ROW_REQ, CMD_PUT, 32'hffff_ffff, 32'hffff_ffff, 0, 1'b0, 32'h0000_0000},
    '{ROW_REQ, CMD_GET, 32'hffff_ffff, 32'hffff_ffff, 1, 1'b1, 32'hffff_ffff},
    '{ROW_REQ, CMD_PUT, 32'hffff_ffff, 32'h0000_0000, 0, 1'b0, 32'h0000_0000},
    '{ROW_REQ, CMD_GET, 32'hffff_ffff, 32'h0000_0000, 1, 1'b1, 32'h0000_0000},
    '{ROW_REQ, CMD_GET, 32'h0000_0000, 32'hffff_ffff, 1, 1'b0, 32'h0000_0000},
    '{ROW_CAP, CMD_GET, 32'h0000_0000, 32'd0,         0, 1'b0, 32'h0000_0000},
    '{ROW_REQ, CMD_PUT, 32'h0000_0001, 32'h0000_0011, 0, 1'b0, 32'h0000_0000},
    '{ROW_REQ, CMD_GET, 32'h8000_0000, 32'h0000_0000, 0, 1'b0, 32'h0000_0000},
    '{ROW_REQ, CMD_GET, 32'h0000_0001, 32'h0000_0000, 0, 1'b0, 32'h0000_0000},
    '{ROW_REQ, CMD_PUT, 32'h0000_0002, 32'h0000_0022, 0, 1'b0, 32'h0000_0000},
    '{ROW_REQ, CMD_GET, 32'h0000_0001, 32'h0000_0000, 0, 1'b0, 32'h0000_0000},
    '{ROW_CAP, CMD_GET, 32'h0000_0000, 32'd31,        0, 1'b0, 32'h0000_0000},
    '{ROW_REQ, CMD_PUT, 32'h0000_0003, 32'h0000_0033, 0, 1'b0, 32'h0000_0000},
    '{ROW_REQ, CMD_GET, 32'h0000_0002, 32'h0000_0000, 0, 1'b0, 32'h0000_0000},
    '{ROW_CAP, CMD_GET, 32'h0000_0000, 32'd2,         0, 1'b0, 32'h0000_0000},
    '{ROW_REQ, CMD_PUT, 32'h0000_0004, 32'h0000_0044, 0, 1'b0, 32'h0000_0000},
    '{ROW_REQ, CMD_PUT, 32'h0000_0005, 32'h0000_0055, 0, 1'b0, 32'h0000_0000},
    '{ROW_REQ, CMD_GET, 32'h0000_0003, 32'h0000_0000, 0, 1'b0, 32'h0000_0000},
    '{ROW_REQ, CMD_GET, 32'h0000_0005, 32'h0000_0000, 0, 1'b0, 32'h0000_0000},
    '{ROW_CAP, CMD_GET, 32'h0000_0000, 32'd16,        0, 1'b0, 32'h0000_0000}
  };

  lru_key_value_cache_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned cap_in_use(input logic [CAP_W-1:0] cap);
    if (cap == 0) return 1;
    if (cap > CACHE_DEPTH) return CACHE_DEPTH;
    return cap;
  endfunction

  // Applies one request to the predicted cache; returns 1 when it yields a read result.
  function automatic bit lru_apply(input logic cmd, input logic [31:0] key,
                                   input logic [31:0] val, output read_t res);
    int          slot;
    int          victim;
    int          free;
    int unsigned r;
    slot = -1;
    res = '0;
    for (int i = 0; i < CACHE_DEPTH; i++) begin
      if (slot < 0 && c_vld[i] && c_key[i] == key) slot = i;
    end
    if (slot >= 0) begin
      if (cmd == CMD_GET) begin
        res.hit = 1'b1;
        res.value = c_val[slot];
      end else begin
        c_val[slot] = val;
      end
      r = c_rank[slot];
      for (int i = 0; i < CACHE_DEPTH; i++) begin
        if (c_vld[i] && c_rank[i] < r) c_rank[i]++;
      end
      c_rank[slot] = 0;
    end else if (cmd == CMD_PUT) begin
      if (c_occ >= cap_in_use(c_cap)) begin
        victim = -1;
        for (int i = 0; i < CACHE_DEPTH; i++) begin
          if (c_vld[i] && (victim < 0 || c_rank[i] > c_rank[victim])) victim = i;
        end
        if (victim >= 0) begin
          c_vld[victim] = 1'b0;
          c_rank[victim] = 0;
          if (c_occ > 0) c_occ--;
        end
      end
      free = -1;
      for (int i = 0; i < CACHE_DEPTH; i++) begin
        if (free < 0 && !c_vld[i]) free = i;
      end
      if (free >= 0) begin
        for (int i = 0; i < CACHE_DEPTH; i++) begin
          if (c_vld[i]) c_rank[i]++;
        end
        c_key[free] = key;
        c_val[free] = val;
        c_vld[free] = 1'b1;
        c_rank[free] = 0;
        c_occ++;
      end
    end
    return cmd == CMD_GET;
  endfunction

  function automatic void flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  task automatic send_req(input logic cmd, input logic [31:0] key, input logic [31:0] val,
                          input bit typed, input logic t_hit, input logic [31:0] t_val);
    read_t res;
    while (!quiet && $urandom_range(99) < 17) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {val, key};
    do @(posedge clk_i); while (!s_axis_tready);
    if (lru_apply(cmd, key, val, res)) begin
      if (typed) begin
        res.hit = t_hit;
        res.value = t_val;
      end
      reads_due.push_back(res);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (reads_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    c_cap = cap;
  endtask

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_req != stall_seen) begin
      stall_seen = stall_req;
      stall_left = 300;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet || ($urandom_range(99) >= 17);
    end
  end

  always @(posedge clk_i) begin
    read_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (reads_due.size() == 0) begin
        flag_error($sformatf("unexpected read result: hit %b value %h",
                             m_axis_tuser, m_axis_tdata));
      end else begin
        want = reads_due.pop_front();
        if (m_axis_tuser !== want.hit || m_axis_tdata !== want.value) begin
          flag_error($sformatf("read mismatch: expected hit %b value %h, got hit %b value %h",
                               want.hit, want.value, m_axis_tuser, m_axis_tdata));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [31:0]      key_pool [20];
    logic [31:0]      edge_keys [4];
    logic [31:0]      key;
    logic [CAP_W-1:0] cap;
    int               pool_n;
    edge_keys = '{32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff};
    for (int i = 0; i < CACHE_DEPTH; i++) begin
      c_key[i] = '0;
      c_val[i] = '0;
      c_vld[i] = 1'b0;
      c_rank[i] = 0;
    end
    c_occ = 0;
    c_cap = CAP_RESET;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int n = 0; n < NUM_ROWS; n++) begin
      if (dir_rows[n].kind == ROW_CAP) begin
        set_capacity(dir_rows[n].val[CAP_W-1:0]);
      end else begin
        send_req(dir_rows[n].cmd, dir_rows[n].key, dir_rows[n].val,
                 dir_rows[n].typed, dir_rows[n].t_hit, dir_rows[n].t_val);
      end
    end

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: cap = 5'd1;
        1: cap = 5'd16;
        2: cap = 5'd31;
        3: cap = 5'd0;
        4: cap = 5'd2;
        5: cap = 5'd17;
        6: cap = 5'($urandom_range(15, 3));
        default: cap = 5'($urandom_range(31, 0));
      endcase
      set_capacity(cap);
      quiet = (p == 2);
      if (p == 4) stall_req++;
      pool_n = cap_in_use(cap) + 4;
      if (pool_n > 20) pool_n = 20;
      for (int k = 0; k < pool_n; k++) begin
        key_pool[k] = (k < 4) ? edge_keys[k] : $urandom;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 5 && n == PHASE_ITEMS / 2) drain();
        key = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(pool_n - 1)];
        send_req(1'($urandom_range(1)), key, $urandom, 1'b0, 1'b0, '0);
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
